>>> src/cbxf_pkg.sv
// Shared types, constants and helpers for the two-colour checkerboard crossfade.
// Used by the interfaces, the serial divider, the strip writer and the top level.
package cbxf_pkg;

    // Field widths
    localparam int TIME_W  = 32;
    localparam int STEP_W  = 16;
    localparam int COLOR_W = 24;
    localparam int LANE_W  = 2;
    localparam int ROW_W   = 5;
    localparam int IDX_W   = 6;
    localparam int CFG_W   = 32;
    localparam int CFG_A_W = 3;

    // Serial divider widths: 32-bit dividend, divisor up to four times the step
    localparam int DIV_N_W = 32;
    localparam int DIV_D_W = 18;
    localparam int DIV_C_W = $clog2(DIV_N_W);

    // Upper bound on strip writes in one frame
    localparam int RESULT_CAP = 64;
    localparam int CAP_W      = $clog2(RESULT_CAP);

    // Default geometry limits
    localparam int MAX_LANES_DEF = 2;
    localparam int MAX_ROWS_DEF  = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_A_W-1:0] REG_LANES = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_ROWS  = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_MODE  = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_STEP  = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_COL_A = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_COL_B = 3'd5;
    localparam logic [CFG_A_W-1:0] REG_REF   = 3'd6;

    // Register values after reset
    localparam logic [LANE_W-1:0]  RST_LANES = 2'd1;
    localparam logic [ROW_W-1:0]   RST_ROWS  = 5'd10;
    localparam logic               RST_MODE  = 1'b0;
    localparam logic [STEP_W-1:0]  RST_STEP  = 16'd256;
    localparam logic [COLOR_W-1:0] RST_COL_A = 24'hFF0000;
    localparam logic [COLOR_W-1:0] RST_COL_B = 24'h0000FF;
    localparam logic [TIME_W-1:0]  RST_REF   = 32'd0;

    // Colour channel being worked on
    typedef enum logic [1:0] {
        CH_GREEN,
        CH_RED,
        CH_BLUE
    } t_chan;

    // Request to the serial divider
    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } t_div_cmd;

    // Answer from the serial divider
    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
        logic [DIV_D_W-1:0] remainder;
    } t_div_rsp;

    // Frame hand-over to the strip writer
    typedef struct packed {
        logic               start;
        logic [LANE_W-1:0]  lanes;
        logic [ROW_W-1:0]   rows;
        logic               pair;
        logic [COLOR_W-1:0] col_even;
        logic [COLOR_W-1:0] col_odd;
    } t_emit_cmd;

    // Pick one 8-bit channel out of a packed red/green/blue word
    function automatic logic [7:0] chan_byte(input logic [COLOR_W-1:0] color,
                                             input t_chan ch);
        logic [7:0] v;
        unique case (ch)
            CH_GREEN: v = color[15:8];
            CH_RED:   v = color[23:16];
            CH_BLUE:  v = color[7:0];
            default:  v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

>>> src/cbxf_if.sv
// Valid/ready channel interfaces for frame ticks in and strip writes out.
// Depends on cbxf_pkg for the field widths.
interface cbxf_tick_if;
    logic                          valid;
    logic                          ready;
    logic [cbxf_pkg::TIME_W-1:0]   now_ms;

    modport source (output valid, output now_ms, input ready);
    modport sink   (input valid, input now_ms, output ready);
endinterface

interface cbxf_write_if;
    logic                          valid;
    logic                          ready;
    logic [cbxf_pkg::IDX_W-1:0]    led_index;
    logic [7:0]                    green;
    logic [7:0]                    red;
    logic [7:0]                    blue;
    logic                          last;

    modport source (output valid, output led_index, output green, output red,
                    output blue, output last, input ready);
    modport sink   (input valid, input led_index, input green, input red,
                    input blue, input last, output ready);
endinterface

>>> src/checkerboard_two_color_crossfade_top.sv
// Checkerboard two-colour crossfade. Each tick passes through the phase division, fold
// and clamp, three channel mixes on the one shared bit-serial divider, hand-over to the
// strip writer and idle.
// Writes then leave at one per cycle while the sink is ready (lanes*rows, doubled in
// paired mode), while the next tick is already being worked on.
// Synchronous active-low reset restores the register defaults and empties the outputs.
module checkerboard_two_color_crossfade_top #(
    parameter int MAX_LANES = cbxf_pkg::MAX_LANES_DEF,
    parameter int MAX_ROWS  = cbxf_pkg::MAX_ROWS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    cbxf_tick_if.sink                      i_tick,
    cbxf_write_if.source                   o_wr,
    input  logic                           i_cfg_we,
    input  logic [cbxf_pkg::CFG_A_W-1:0]   i_cfg_idx,
    input  logic [cbxf_pkg::CFG_W-1:0]     i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PHASE,
        S_PWAIT,
        S_FOLD,
        S_CLAMP,
        S_MUL,
        S_DIV,
        S_DWAIT,
        S_HAND
    } t_state;

    // Configuration registers
    logic [cbxf_pkg::LANE_W-1:0]  r_lanes;
    logic [cbxf_pkg::ROW_W-1:0]   r_rows;
    logic                         r_mode;
    logic [cbxf_pkg::STEP_W-1:0]  r_step;
    logic [cbxf_pkg::COLOR_W-1:0] r_col_a;
    logic [cbxf_pkg::COLOR_W-1:0] r_col_b;
    logic [cbxf_pkg::TIME_W-1:0]  r_ref;

    // Frame working state
    t_state                       r_state;
    logic [cbxf_pkg::TIME_W-1:0]  r_time;
    logic [cbxf_pkg::STEP_W-1:0]  r_s;
    logic [cbxf_pkg::DIV_D_W-1:0] r_p;
    logic [cbxf_pkg::DIV_D_W-1:0] r_d;
    logic [cbxf_pkg::STEP_W-1:0]  r_c;
    cbxf_pkg::t_chan              r_ch;
    logic [23:0]                  r_prod;
    logic                         r_neg;
    logic [cbxf_pkg::COLOR_W-1:0] r_even;
    logic [cbxf_pkg::COLOR_W-1:0] r_odd;

    cbxf_pkg::t_div_cmd           div_cmd;
    cbxf_pkg::t_div_rsp           div_rsp;
    cbxf_pkg::t_emit_cmd          emit_cmd;
    logic                         emit_busy;

    logic                         accept;
    logic [18:0]                  h5;
    logic [cbxf_pkg::DIV_D_W-1:0] half5;
    logic [18:0]                  fold;
    logic [18:0]                  excess;
    logic [7:0]                   ch_a;
    logic [7:0]                   ch_b;
    logic [8:0]                   ch_diff;
    logic [7:0]                   ch_mag;
    logic [7:0]                   q;
    logic [7:0]                   t_ofs;
    logic [7:0]                   even_byte;
    logic [7:0]                   odd_byte;
    logic [cbxf_pkg::LANE_W-1:0]  lanes_sat;
    logic [cbxf_pkg::ROW_W-1:0]   rows_sat;

    // Store configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lanes <= cbxf_pkg::RST_LANES;
            r_rows  <= cbxf_pkg::RST_ROWS;
            r_mode  <= cbxf_pkg::RST_MODE;
            r_step  <= cbxf_pkg::RST_STEP;
            r_col_a <= cbxf_pkg::RST_COL_A;
            r_col_b <= cbxf_pkg::RST_COL_B;
            r_ref   <= cbxf_pkg::RST_REF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cbxf_pkg::REG_LANES: r_lanes <= i_cfg_data[cbxf_pkg::LANE_W-1:0];
                cbxf_pkg::REG_ROWS:  r_rows  <= i_cfg_data[cbxf_pkg::ROW_W-1:0];
                cbxf_pkg::REG_MODE:  r_mode  <= i_cfg_data[0];
                cbxf_pkg::REG_STEP:  r_step  <= i_cfg_data[cbxf_pkg::STEP_W-1:0];
                cbxf_pkg::REG_COL_A: r_col_a <= i_cfg_data[cbxf_pkg::COLOR_W-1:0];
                cbxf_pkg::REG_COL_B: r_col_b <= i_cfg_data[cbxf_pkg::COLOR_W-1:0];
                cbxf_pkg::REG_REF:   r_ref   <= i_cfg_data[cbxf_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Fade arithmetic between the sequencer's registers
    always_comb begin
        accept    = i_tick.valid && (r_state == S_IDLE);
        // floor(5s/2) and the distance of the phase from it
        h5        = {3'b000, r_s} + {1'b0, r_s, 2'b00};
        half5     = h5[18:1];
        fold      = {1'b0, r_p} - {1'b0, half5};
        excess    = {1'b0, r_d} - {4'b0000, r_s[cbxf_pkg::STEP_W-1:1]};
        // Signed colour difference of the current channel, as sign and magnitude
        ch_a      = cbxf_pkg::chan_byte(r_col_a, r_ch);
        ch_b      = cbxf_pkg::chan_byte(r_col_b, r_ch);
        ch_diff   = {1'b0, ch_b} - {1'b0, ch_a};
        ch_mag    = ch_diff[8] ? 8'(-ch_diff) : ch_diff[7:0];
        // Truncated quotient, signed back; odd cells run the other way
        q         = div_rsp.quotient[7:0];
        t_ofs     = r_neg ? 8'(-q) : q;
        even_byte = ch_a + t_ofs;
        odd_byte  = ch_b - t_ofs;
        lanes_sat = (32'(r_lanes) > MAX_LANES) ? cbxf_pkg::LANE_W'(MAX_LANES) : r_lanes;
        rows_sat  = (32'(r_rows) > MAX_ROWS) ? cbxf_pkg::ROW_W'(MAX_ROWS) : r_rows;
    end

    // Drive the shared divider and the strip writer
    always_comb begin
        div_cmd.start    = (r_state == S_PHASE) || (r_state == S_DIV);
        div_cmd.dividend = (r_state == S_PHASE) ? r_time
                                                : cbxf_pkg::DIV_N_W'(r_prod);
        div_cmd.divisor  = (r_state == S_PHASE) ? {r_s, 2'b00}
                                                : cbxf_pkg::DIV_D_W'(r_s);
        emit_cmd.start    = (r_state == S_HAND) && !emit_busy;
        emit_cmd.lanes    = lanes_sat;
        emit_cmd.rows     = rows_sat;
        emit_cmd.pair     = r_mode;
        emit_cmd.col_even = r_even;
        emit_cmd.col_odd  = r_odd;
    end

    // Sequence one tick through phase, fade amount, the three channel mixes and the hand-over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= cbxf_pkg::CH_GREEN;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_time  <= i_tick.now_ms - r_ref;
                        r_s     <= (r_step == '0) ? cbxf_pkg::STEP_W'(1) : r_step;
                        r_state <= S_PHASE;
                    end
                end
                S_PHASE: r_state <= S_PWAIT;
                S_PWAIT: begin
                    if (div_rsp.done) begin
                        r_p     <= div_rsp.remainder;
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    r_d     <= fold[18] ? cbxf_pkg::DIV_D_W'(-fold) : fold[17:0];
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    if (excess[18]) begin
                        r_c <= '0;
                    end else if (excess[17:0] > {2'b00, r_s}) begin
                        r_c <= r_s;
                    end else begin
                        r_c <= excess[cbxf_pkg::STEP_W-1:0];
                    end
                    r_ch    <= cbxf_pkg::CH_GREEN;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= r_c * ch_mag;
                    r_neg   <= ch_diff[8];
                    r_state <= S_DIV;
                end
                S_DIV: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (div_rsp.done) begin
                        unique case (r_ch)
                            cbxf_pkg::CH_GREEN: begin
                                r_even[15:8] <= even_byte;
                                r_odd[15:8]  <= odd_byte;
                                r_ch         <= cbxf_pkg::CH_RED;
                                r_state      <= S_MUL;
                            end
                            cbxf_pkg::CH_RED: begin
                                r_even[23:16] <= even_byte;
                                r_odd[23:16]  <= odd_byte;
                                r_ch          <= cbxf_pkg::CH_BLUE;
                                r_state       <= S_MUL;
                            end
                            default: begin
                                r_even[7:0] <= even_byte;
                                r_odd[7:0]  <= odd_byte;
                                r_state     <= S_HAND;
                            end
                        endcase
                    end
                end
                S_HAND: begin
                    if (!emit_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_tick.ready = (r_state == S_IDLE);

    cbxf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (div_cmd),
        .o_rsp   (div_rsp)
    );

    cbxf_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (emit_cmd),
        .o_busy  (emit_busy),
        .o_wr    (o_wr)
    );

endmodule

>>> src/cbxf_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on cbxf_pkg for the request and answer structs.
module cbxf_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cbxf_pkg::t_div_cmd  i_cmd,
    output cbxf_pkg::t_div_rsp  o_rsp
);

    logic [cbxf_pkg::DIV_D_W-1:0] r_rem;
    logic [cbxf_pkg::DIV_N_W-1:0] r_quo;
    logic [cbxf_pkg::DIV_D_W-1:0] r_div;
    logic [cbxf_pkg::DIV_C_W-1:0] r_cnt;
    logic                         r_busy;
    logic                         r_done;

    logic [cbxf_pkg::DIV_D_W:0]   trial;
    logic                         fits;
    logic [cbxf_pkg::DIV_D_W-1:0] n_rem;

    // Shift in the next dividend bit and try to subtract the divisor
    always_comb begin
        trial = {r_rem, r_quo[cbxf_pkg::DIV_N_W-1]};
        fits  = trial >= {1'b0, r_div};
        n_rem = fits ? cbxf_pkg::DIV_D_W'(trial - {1'b0, r_div})
                     : trial[cbxf_pkg::DIV_D_W-1:0];
    end

    // Iterate until every dividend bit has passed through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_cmd.dividend;
                r_div  <= i_cmd.divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[cbxf_pkg::DIV_N_W-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == cbxf_pkg::DIV_C_W'(cbxf_pkg::DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

>>> src/cbxf_emit.sv
// Strip writer: walks lanes and rows, forms LED indexes and drives the output register.
// Depends on cbxf_pkg and the cbxf_write_if interface.
module cbxf_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cbxf_pkg::t_emit_cmd i_cmd,
    output logic                o_busy,
    cbxf_write_if.source        o_wr
);

    logic                             r_busy;
    logic [cbxf_pkg::LANE_W-1:0]      r_lane;
    logic [cbxf_pkg::ROW_W-1:0]       r_row;
    logic                             r_mirror;
    logic [cbxf_pkg::CAP_W-1:0]       r_cnt;
    logic [cbxf_pkg::IDX_W-1:0]       r_base;
    logic [cbxf_pkg::LANE_W-1:0]      r_lanes;
    logic [cbxf_pkg::ROW_W-1:0]       r_rows;
    logic                             r_pair;
    logic [cbxf_pkg::COLOR_W-1:0]     r_col_even;
    logic [cbxf_pkg::COLOR_W-1:0]     r_col_odd;

    logic                             r_ovalid;
    logic [cbxf_pkg::IDX_W-1:0]       r_oidx;
    logic [cbxf_pkg::COLOR_W-1:0]     r_ocol;
    logic                             r_olast;

    logic                             load;
    logic                             row_end;
    logic                             lane_end;
    logic                             cap_hit;
    logic                             wr_last;
    logic [cbxf_pkg::IDX_W-1:0]       rows_x1;
    logic [cbxf_pkg::IDX_W-1:0]       rows_x2;
    logic [cbxf_pkg::IDX_W-1:0]       idx;
    logic [cbxf_pkg::COLOR_W-1:0]     col;

    // Work out the current write
    always_comb begin
        load     = r_busy && (!r_ovalid || o_wr.ready);
        row_end  = r_row == r_rows - 1'b1;
        lane_end = r_lane == r_lanes - 1'b1;
        cap_hit  = r_cnt == cbxf_pkg::CAP_W'(cbxf_pkg::RESULT_CAP - 1);
        wr_last  = (r_pair && !r_mirror) ? cap_hit : ((row_end && lane_end) || cap_hit);
        rows_x1  = cbxf_pkg::IDX_W'(r_rows);
        rows_x2  = cbxf_pkg::IDX_W'({r_rows, 1'b0});
        idx      = r_mirror ? r_base + rows_x2 - 1'b1 - cbxf_pkg::IDX_W'(r_row)
                            : r_base + cbxf_pkg::IDX_W'(r_row);
        col      = (r_lane[0] ^ r_row[0]) ? r_col_odd : r_col_even;
    end

    // Walk the cells of one frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.start) begin
            r_busy     <= (i_cmd.lanes != '0) && (i_cmd.rows != '0);
            r_lane     <= '0;
            r_row      <= '0;
            r_mirror   <= 1'b0;
            r_cnt      <= '0;
            r_base     <= '0;
            r_lanes    <= i_cmd.lanes;
            r_rows     <= i_cmd.rows;
            r_pair     <= i_cmd.pair;
            r_col_even <= i_cmd.col_even;
            r_col_odd  <= i_cmd.col_odd;
        end else if (load) begin
            r_cnt <= r_cnt + 1'b1;
            if (wr_last) begin
                r_busy <= 1'b0;
            end else if (r_pair && !r_mirror) begin
                r_mirror <= 1'b1;
            end else begin
                r_mirror <= 1'b0;
                if (row_end) begin
                    r_row  <= '0;
                    r_lane <= r_lane + 1'b1;
                    r_base <= r_base + (r_pair ? rows_x2 : rows_x1);
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end
        end
    end

    // Hold each write until the sink takes the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load) begin
            r_ovalid <= 1'b1;
            r_oidx   <= idx;
            r_ocol   <= col;
            r_olast  <= wr_last;
        end else if (o_wr.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_busy         = r_busy;
    assign o_wr.valid     = r_ovalid;
    assign o_wr.led_index = r_oidx;
    assign o_wr.red       = r_ocol[23:16];
    assign o_wr.green     = r_ocol[15:8];
    assign o_wr.blue      = r_ocol[7:0];
    assign o_wr.last      = r_olast;

endmodule

>>> tb/tb_top.sv
// Self-checking bench for the two-colour checkerboard crossfade top level.
// Depends on cbxf_pkg, the cbxf_tick_if / cbxf_write_if interfaces and the top module.
// Predicts every strip write per frame tick and checks each write as it leaves the block.
`timescale 1ns / 100ps

module tb_top;

    import cbxf_pkg::*;

    // Index with no register behind it
    localparam logic [CFG_A_W-1:0] REG_NONE = 3'd7;

    // Longest run of cycles with no transaction before the run is abandoned
    localparam int STALL_LIMIT   = 4000;
    // Quiet time after the last write so that a frame without writes has finished
    localparam int SETTLE_CYCLES = 400;

    typedef struct packed {
        logic [IDX_W-1:0] led_index;
        logic [7:0]       green;
        logic [7:0]       red;
        logic [7:0]       blue;
        logic             last;
    } strip_write_t;

    // Holds a copy of the registers and the strip writes still owed by the block
    class crossfade_scoreboard;
        logic [LANE_W-1:0]  lane_reg;
        logic [ROW_W-1:0]   row_reg;
        logic               pair_reg;
        logic [STEP_W-1:0]  step_reg;
        logic [COLOR_W-1:0] col_a_reg;
        logic [COLOR_W-1:0] col_b_reg;
        logic [TIME_W-1:0]  ref_reg;
        strip_write_t       due_writes[$];
        int                 errors;

        function new();
            lane_reg  = RST_LANES;
            row_reg   = RST_ROWS;
            pair_reg  = RST_MODE;
            step_reg  = RST_STEP;
            col_a_reg = RST_COL_A;
            col_b_reg = RST_COL_B;
            ref_reg   = RST_REF;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_A_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_LANES: lane_reg  = val[LANE_W-1:0];
                REG_ROWS:  row_reg   = val[ROW_W-1:0];
                REG_MODE:  pair_reg  = val[0];
                REG_STEP:  step_reg  = val[STEP_W-1:0];
                REG_COL_A: col_a_reg = val[COLOR_W-1:0];
                REG_COL_B: col_b_reg = val[COLOR_W-1:0];
                REG_REF:   ref_reg   = val[TIME_W-1:0];
                default: ;
            endcase
        endfunction

        // Zero step behaves as a step of one
        function logic [31:0] eff_step();
            return (step_reg == '0) ? 32'd1 : {16'd0, step_reg};
        endfunction

        // Linear mix of one channel, division truncating toward zero
        function logic [7:0] mix(longint c, longint s, logic [7:0] from, logic [7:0] to);
            longint f;
            longint t;
            longint v;
            f = from;
            t = to;
            v = (c * (t - f)) / s + f;
            return v[7:0];
        endfunction

        function void add_write(inout int count, input logic [31:0] idx,
                                input logic [COLOR_W-1:0] from, input logic [COLOR_W-1:0] to,
                                input longint c, input longint s);
            strip_write_t w;
            if (count >= RESULT_CAP)
                return;
            w.led_index = idx[IDX_W-1:0];
            w.green     = mix(c, s, from[15:8], to[15:8]);
            w.red       = mix(c, s, from[23:16], to[23:16]);
            w.blue      = mix(c, s, from[7:0], to[7:0]);
            w.last      = 1'b0;
            due_writes.push_back(w);
            count++;
        endfunction

        // Work out the fade amount for this tick and queue the whole frame
        function void note_tick(logic [TIME_W-1:0] now);
            logic [31:0]        s;
            logic [31:0]        phase;
            logic [31:0]        lanes;
            logic [31:0]        rows;
            longint             d;
            longint             c;
            logic [COLOR_W-1:0] from_col;
            logic [COLOR_W-1:0] to_col;
            int                 count;
            s     = eff_step();
            lanes = (lane_reg > MAX_LANES_DEF) ? MAX_LANES_DEF : lane_reg;
            rows  = (row_reg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : row_reg;
            phase = (now - ref_reg) % (32'd4 * s);
            d     = longint'(phase) - longint'((32'd5 * s) / 32'd2);
            if (d < 0)
                d = -d;
            c = d - longint'(s / 32'd2);
            if (c < 0)
                c = 0;
            if (c > longint'(s))
                c = longint'(s);
            count = 0;
            for (int i = 0; i < lanes; i++) begin
                for (int j = 0; j < rows; j++) begin
                    // Even cells fade A to B, odd cells the other way
                    from_col = ((i + j) % 2 == 0) ? col_a_reg : col_b_reg;
                    to_col   = ((i + j) % 2 == 0) ? col_b_reg : col_a_reg;
                    if (!pair_reg) begin
                        add_write(count, i * rows + j, from_col, to_col, c, longint'(s));
                    end else begin
                        add_write(count, 2 * i * rows + j, from_col, to_col, c, longint'(s));
                        add_write(count, 2 * (i + 1) * rows - j - 1, from_col, to_col, c,
                                  longint'(s));
                    end
                end
            end
            if (count > 0)
                due_writes[due_writes.size() - 1].last = 1'b1;
        endfunction

        function void report(string field, int unsigned want, int unsigned got);
            $display("%0t: strip write %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
            errors++;
        endfunction

        // Compare one accepted write with the oldest one owed
        function void check_write(strip_write_t got);
            strip_write_t want;
            if (due_writes.size() == 0) begin
                $display("%0t: unexpected strip write, expected none, actual idx %0d rgb %h%h%h last %0b",
                         $time, got.led_index, got.red, got.green, got.blue, got.last);
                errors++;
                return;
            end
            want = due_writes.pop_front();
            if (got.led_index !== want.led_index)
                report("led_index", want.led_index, got.led_index);
            if (got.green !== want.green)
                report("green", want.green, got.green);
            if (got.red !== want.red)
                report("red", want.red, got.red);
            if (got.blue !== want.blue)
                report("blue", want.blue, got.blue);
            if (got.last !== want.last)
                report("last", want.last, got.last);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_A_W-1:0]   cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    bit                   calm = 1'b0;
    int                   quiet_cycles = 0;
    crossfade_scoreboard  fade_sb = new();

    cbxf_tick_if  tick_bus ();
    cbxf_write_if strip_bus ();

    checkerboard_two_color_crossfade_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (tick_bus),
        .o_wr       (strip_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Stall the write channel at random, except in the calm stretch
    initial begin
        strip_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n)
                strip_bus.ready <= 1'b0;
            else if (calm)
                strip_bus.ready <= 1'b1;
            else
                strip_bus.ready <= ($urandom_range(99) >= 32);
        end
    end

    // Watch both channels; abandon the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (strip_bus.valid && strip_bus.ready)
                fade_sb.check_write(strip_write_t'{led_index: strip_bus.led_index,
                                                   green: strip_bus.green,
                                                   red: strip_bus.red,
                                                   blue: strip_bus.blue,
                                                   last: strip_bus.last});
            if (tick_bus.valid && tick_bus.ready)
                fade_sb.note_tick(tick_bus.now_ms);
            if ((strip_bus.valid && strip_bus.ready) || (tick_bus.valid && tick_bus.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("tb_top: FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Write one register; takes effect at the next edge
    task automatic cfg_write(input logic [CFG_A_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        fade_sb.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Fill the unused upper bits of a register write with noise
    function automatic logic [CFG_W-1:0] noisy(logic [CFG_W-1:0] val, int width);
        logic [CFG_W-1:0] junk;
        junk = $urandom();
        return val | (junk << width);
    endfunction

    // Program every register; with junk set, also dirty the upper bits and hit the spare index
    task automatic set_all(input logic [31:0] lanes, input logic [31:0] rows,
                           input logic [31:0] mode, input logic [31:0] step,
                           input logic [31:0] col_a, input logic [31:0] col_b,
                           input logic [31:0] ref_t, input bit junk);
        cfg_write(REG_LANES, junk ? noisy(lanes, LANE_W) : lanes);
        cfg_write(REG_ROWS,  junk ? noisy(rows, ROW_W) : rows);
        cfg_write(REG_MODE,  junk ? noisy(mode, 1) : mode);
        cfg_write(REG_STEP,  junk ? noisy(step, STEP_W) : step);
        cfg_write(REG_COL_A, junk ? noisy(col_a, COLOR_W) : col_a);
        cfg_write(REG_COL_B, junk ? noisy(col_b, COLOR_W) : col_b);
        if (junk)
            cfg_write(REG_NONE, $urandom());
        cfg_write(REG_REF, ref_t);
        cfg_we <= 1'b0;
    endtask

    // Offer one tick, idling first at random; valid stays high afterwards
    task automatic send_tick(input logic [TIME_W-1:0] now);
        while (!calm && $urandom_range(99) < 32) begin
            tick_bus.valid <= 1'b0;
            repeat (($urandom_range(7) == 0) ? $urandom_range(20, 200) : 1) @(posedge i_clk);
        end
        tick_bus.valid  <= 1'b1;
        tick_bus.now_ms <= now;
        do
            @(posedge i_clk);
        while (!tick_bus.ready);
    endtask

    // Hold off ticks until every owed write has left, then let the block go quiet
    task automatic drain_and_settle();
        tick_bus.valid <= 1'b0;
        while (fade_sb.due_writes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Pick a random setting, biased toward the saturating and empty geometries now and then
    task automatic random_setting();
        logic [31:0] lanes_v;
        logic [31:0] rows_v;
        logic [31:0] step_v;
        logic [31:0] col_a_v;
        logic [31:0] col_b_v;
        int          pick;
        pick    = $urandom_range(9);
        lanes_v = (pick == 0) ? 0 : (pick == 9) ? 3 : $urandom_range(1, 2);
        pick    = $urandom_range(19);
        rows_v  = (pick == 0) ? 0 : (pick == 19) ? $urandom_range(17, 31) :
                  (pick == 18) ? 16 : $urandom_range(1, 16);
        case ($urandom_range(7))
            0:       step_v = 0;
            1:       step_v = 1;
            2:       step_v = 16'hFFFF;
            3, 4:    step_v = $urandom_range(2, 16);
            default: step_v = $urandom_range(0, 16'hFFFF);
        endcase
        pick    = $urandom_range(7);
        col_a_v = (pick == 0) ? 0 : (pick == 1) ? 24'hFFFFFF : $urandom_range(0, 24'hFFFFFF);
        pick    = $urandom_range(7);
        col_b_v = (pick == 0) ? 0 : (pick == 1) ? 24'hFFFFFF : $urandom_range(0, 24'hFFFFFF);
        set_all(lanes_v, rows_v, $urandom_range(1), step_v, col_a_v, col_b_v, $urandom(), 1'b1);
    endtask

    initial begin
        logic [TIME_W-1:0] now;
        i_rst_n         = 1'b0;
        tick_bus.valid  = 1'b0;
        tick_bus.now_ms = '0;
        cfg_we          = 1'b0;
        cfg_idx         = REG_LANES;
        cfg_data        = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: one lane of ten, step 256, red to blue
        send_tick(32'd0);
        send_tick(32'd640);
        send_tick(32'd768);
        send_tick(32'd896);
        send_tick(32'd1023);
        send_tick(32'hFFFF_FFFF);
        drain_and_settle();

        // Zero step, full paired frame, time wrap through the reference
        set_all(2, 16, 1, 0, 24'hFFFFFF, 24'h000000, 32'hFFFF_FFFF, 1'b0);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'd0);
        send_tick(32'd1);
        send_tick(32'd2);
        drain_and_settle();

        // Largest step with lane and row counts beyond the maximum
        set_all(3, 31, 0, 16'hFFFF, 24'h000000, 24'hFFFFFF, 32'h8000_0000, 1'b0);
        send_tick(32'h8000_0000);
        send_tick(32'h8000_0000 + 32'd163837);
        send_tick(32'h8000_0000 + 32'd196605);
        send_tick(32'h8000_0000 + 32'd229371);
        send_tick(32'h8000_0000 + 32'd262139);
        drain_and_settle();

        // No lanes, then no rows: frames without writes
        set_all(0, 16, 1, 100, 24'h00FF00, 24'hFF00FF, 32'd0, 1'b1);
        send_tick(32'd50);
        send_tick(32'd350);
        drain_and_settle();
        set_all(2, 0, 0, 100, 24'h00FF00, 24'hFF00FF, 32'd0, 1'b1);
        send_tick(32'd50);
        send_tick(32'd350);
        drain_and_settle();

        // Single cell in paired mode, step of one
        set_all(1, 1, 1, 1, 24'h123456, 24'hABCDEF, 32'd0, 1'b0);
        send_tick(32'd0);
        send_tick(32'd1);
        send_tick(32'd2);
        drain_and_settle();

        // Random settings, half the ticks placed no more than four steps plus three after the reference
        for (int ph = 0; ph < 8; ph++) begin
            calm = (ph == 3);
            random_setting();
            for (int n = 0; n < 32; n++) begin
                if ($urandom_range(1))
                    now = $urandom();
                else
                    now = fade_sb.ref_reg + $urandom_range(0, 4 * fade_sb.eff_step() + 3);
                send_tick(now);
            end
            drain_and_settle();
        end

        if (fade_sb.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
